/* rtl/dmht_pkg.sv */
// Shared types and constants of the direct-mapped hash table.
`timescale 1ns / 1ps
`default_nettype none
package dmht_pkg;

  localparam int unsigned LEN_W       = 11;
  localparam int unsigned HASH_W      = 32;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned VALUE_W     = 32;
  localparam int unsigned VLEN_W      = 16;
  localparam int unsigned FUNC_W      = 2;
  localparam int unsigned HASH_SHIFT  = 5;
  localparam logic [HASH_W-1:0] HASH_SEED = 32'd5381;

  // modulo unit: MOD_BITS quotient bits retired per cycle
  localparam int unsigned MOD_BITS    = 4;
  localparam int unsigned MOD_STEPS   = HASH_W / MOD_BITS;
  localparam int unsigned STEP_W      = $clog2(MOD_STEPS);

  localparam int unsigned QUEUE_DEPTH = 2;

  // configuration port
  localparam int unsigned APB_ADDR_W  = 3;
  localparam int unsigned APB_DATA_W  = 32;
  localparam logic        REG_TABLE_LEN = 1'b0;   // register index (paddr[2])
  localparam logic [LEN_W-1:0] TABLE_LEN_RESET = 11'd1024;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_GET    = 2'd1,
    FUNC_REMOVE = 2'd2
  } func_t;

  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [HASH_W-1:0]  hash;
    logic [VALUE_W-1:0] value;
    logic [VLEN_W-1:0]  length;
  } job_t;

  typedef struct packed {
    logic               valid;
    logic [VALUE_W-1:0] value;
    logic [VLEN_W-1:0]  length;
  } slot_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_READ,
    ST_EXEC
  } back_state_t;

endpackage
`default_nettype wire

/* rtl/dmht_if.sv */
// Item channels: key bytes in, table results out.
`timescale 1ns / 1ps
`default_nettype none
interface dmht_in_if;
  logic                              valid;
  logic                              ready;
  logic [dmht_pkg::FUNC_W-1:0]       func;
  logic [dmht_pkg::BYTE_W-1:0]       key_byte;
  logic                              key_last;
  logic [dmht_pkg::VALUE_W-1:0]      value_word;
  logic [dmht_pkg::VLEN_W-1:0]       value_length;

  modport source (output valid, func, key_byte, key_last, value_word, value_length,
                  input ready);
  modport sink   (input valid, func, key_byte, key_last, value_word, value_length,
                  output ready);
endinterface

interface dmht_out_if;
  logic                              valid;
  logic                              ready;
  logic                              found;
  logic [dmht_pkg::VALUE_W-1:0]      stored_value;
  logic [dmht_pkg::VLEN_W-1:0]       stored_length;

  modport source (output valid, found, stored_value, stored_length, input ready);
  modport sink   (input valid, found, stored_value, stored_length, output ready);
endinterface
`default_nettype wire

/* rtl/dmht_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module dmht_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

/* rtl/dmht_fifo.sv */
// Short job queue between the hashing front end and the table back end.
`timescale 1ns / 1ps
`default_nettype none
module dmht_fifo (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire dmht_pkg::job_t  push_data,
  output      logic            push_ready,
  input  wire logic            pop,
  output      dmht_pkg::job_t  pop_data,
  output      logic            pop_valid
);

  localparam int unsigned PTR_W = (dmht_pkg::QUEUE_DEPTH > 1) ?
                                  $clog2(dmht_pkg::QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(dmht_pkg::QUEUE_DEPTH + 1);

  dmht_pkg::job_t entries [dmht_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != CNT_W'(dmht_pkg::QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = entries[rd_ptr];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(dmht_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(dmht_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/dmht_front.sv */
// Front end: takes key bytes, runs the djb2 hash and queues a job per key.
`timescale 1ns / 1ps
`default_nettype none
module dmht_front (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            enable,
  dmht_in_if.sink              req,
  output      logic            push,
  output      dmht_pkg::job_t  push_data,
  input  wire logic            push_ready
);

  logic [dmht_pkg::HASH_W-1:0] running_hash;
  logic [dmht_pkg::HASH_W-1:0] hash_next;
  logic                        accept;

  assign req.ready = enable && push_ready;
  assign accept    = req.valid && req.ready;

  // hash*33 + byte, wrapping at 32 bits
  assign hash_next = (running_hash << dmht_pkg::HASH_SHIFT) + running_hash
                   + dmht_pkg::HASH_W'(req.key_byte);

  assign push             = accept && req.key_last;
  assign push_data.func   = req.func;
  assign push_data.hash   = hash_next;
  assign push_data.value  = req.value_word;
  assign push_data.length = req.value_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      running_hash <= dmht_pkg::HASH_SEED;
    end else if (accept) begin
      running_hash <= req.key_last ? dmht_pkg::HASH_SEED : hash_next;
    end
  end

endmodule
`default_nettype wire

/* rtl/dmht_back.sv */
// Back end: slot index by hash modulo length, table access and result register.
`timescale 1ns / 1ps
`default_nettype none
module dmht_back #(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic [dmht_pkg::LEN_W-1:0]  table_len,
  input  wire logic                        job_valid,
  input  wire dmht_pkg::job_t              job,
  output      logic                        job_pop,
  output      logic                        table_ready,
  dmht_out_if.source                       rsp
);

  localparam int unsigned IDX_W     = $clog2(TABLE_DEPTH);
  localparam int unsigned LEN_W     = dmht_pkg::LEN_W;
  localparam int unsigned HASH_W    = dmht_pkg::HASH_W;
  localparam int unsigned SLOT_W    = $bits(dmht_pkg::slot_t);
  localparam int unsigned DEPTH_CAP = (TABLE_DEPTH > 2047) ? 2047 : TABLE_DEPTH;

  dmht_pkg::back_state_t state;
  dmht_pkg::back_state_t state_next;

  logic [IDX_W-1:0]             clr_addr;
  logic [HASH_W-1:0]            dividend;
  logic [HASH_W-1:0]            dividend_next;
  logic [LEN_W-1:0]             rem;
  logic [LEN_W-1:0]             rem_next;
  logic [LEN_W-1:0]             divisor;
  logic [LEN_W-1:0]             eff_len;
  logic [dmht_pkg::STEP_W-1:0]  step;
  logic [IDX_W-1:0]             slot_idx;
  logic [dmht_pkg::FUNC_W-1:0]  job_func;
  logic [dmht_pkg::VALUE_W-1:0] job_value;
  logic [dmht_pkg::VLEN_W-1:0]  job_length;

  logic                         ram_we;
  logic [IDX_W-1:0]             ram_waddr;
  dmht_pkg::slot_t              ram_wslot;
  logic                         ram_re;
  logic [SLOT_W-1:0]            ram_rdata;
  dmht_pkg::slot_t              rd_slot;

  logic                         res_valid;
  logic                         res_found;
  logic [dmht_pkg::VALUE_W-1:0] res_value;
  logic [dmht_pkg::VLEN_W-1:0]  res_length;
  logic                         out_free;
  logic                         exec_go;
  logic                         found_new;
  logic [dmht_pkg::VALUE_W-1:0] value_new;
  logic [dmht_pkg::VLEN_W-1:0]  length_new;

  assign rd_slot = dmht_pkg::slot_t'(ram_rdata);

  // zero acts as one, above the table depth saturates
  always_comb begin
    if (table_len == '0) begin
      eff_len = LEN_W'(1);
    end else if (table_len > LEN_W'(DEPTH_CAP)) begin
      eff_len = LEN_W'(DEPTH_CAP);
    end else begin
      eff_len = table_len;
    end
  end

  // restoring modulo, MOD_BITS dividend bits per cycle; rem stays below divisor
  always_comb begin
    logic [LEN_W-1:0]  r;
    logic [HASH_W-1:0] d;
    logic [LEN_W:0]    rs;
    r  = rem;
    d  = dividend;
    rs = '0;
    for (int i = 0; i < dmht_pkg::MOD_BITS; i++) begin
      rs = {r, d[HASH_W-1]};
      d  = d << 1;
      if (rs >= {1'b0, divisor}) begin
        rs = rs - {1'b0, divisor};
      end
      r = rs[LEN_W-1:0];
    end
    rem_next      = r;
    dividend_next = d;
  end

  assign out_free = !res_valid || rsp.ready;
  assign exec_go  = (state == dmht_pkg::ST_EXEC) && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dmht_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      dmht_pkg::ST_CLEAR: begin
        if (clr_addr == IDX_W'(TABLE_DEPTH - 1)) begin
          state_next = dmht_pkg::ST_IDLE;
        end
      end
      dmht_pkg::ST_IDLE: begin
        if (job_valid) begin
          state_next = dmht_pkg::ST_DIV;
        end
      end
      dmht_pkg::ST_DIV: begin
        if (step == dmht_pkg::STEP_W'(dmht_pkg::MOD_STEPS - 1)) begin
          state_next = dmht_pkg::ST_READ;
        end
      end
      dmht_pkg::ST_READ: begin
        state_next = dmht_pkg::ST_EXEC;
      end
      dmht_pkg::ST_EXEC: begin
        if (out_free) begin
          state_next = dmht_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = dmht_pkg::ST_CLEAR;
      end
    endcase
  end

  // result of the operation against the slot just read
  always_comb begin
    found_new  = 1'b0;
    value_new  = '0;
    length_new = '0;
    case (job_func) inside
      dmht_pkg::FUNC_INSERT: begin
        found_new  = 1'b1;
        value_new  = job_value;
        length_new = job_length;
      end
      dmht_pkg::FUNC_GET, dmht_pkg::FUNC_REMOVE: begin
        if (rd_slot.valid) begin
          found_new  = 1'b1;
          value_new  = rd_slot.value;
          length_new = rd_slot.length;
        end
      end
      default: begin
        found_new = 1'b0;
      end
    endcase
  end

  always_comb begin
    job_pop          = 1'b0;
    ram_re           = 1'b0;
    ram_we           = 1'b0;
    ram_waddr        = slot_idx;
    ram_wslot.valid  = 1'b0;
    ram_wslot.value  = job_value;
    ram_wslot.length = job_length;
    unique case (state)
      dmht_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
      end
      dmht_pkg::ST_IDLE: begin
        job_pop = job_valid;
      end
      dmht_pkg::ST_DIV: begin
        job_pop = 1'b0;
      end
      dmht_pkg::ST_READ: begin
        ram_re = 1'b1;
      end
      dmht_pkg::ST_EXEC: begin
        if (job_func == dmht_pkg::FUNC_INSERT) begin
          ram_we          = out_free;
          ram_wslot.valid = 1'b1;
        end else if (job_func == dmht_pkg::FUNC_REMOVE) begin
          // only the valid flag matters once cleared
          ram_we = out_free && rd_slot.valid;
        end
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (state == dmht_pkg::ST_CLEAR) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (state == dmht_pkg::ST_IDLE && job_valid) begin
      dividend   <= job.hash;
      rem        <= '0;
      divisor    <= eff_len;
      step       <= '0;
      job_func   <= job.func;
      job_value  <= job.value;
      job_length <= job.length;
    end else if (state == dmht_pkg::ST_DIV) begin
      dividend <= dividend_next;
      rem      <= rem_next;
      step     <= step + 1'b1;
      slot_idx <= IDX_W'(rem_next);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (exec_go) begin
      res_valid <= 1'b1;
    end else if (rsp.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_go) begin
      res_found  <= found_new;
      res_value  <= value_new;
      res_length <= length_new;
    end
  end

  assign table_ready       = (state != dmht_pkg::ST_CLEAR);
  assign rsp.valid         = res_valid;
  assign rsp.found         = res_found;
  assign rsp.stored_value  = res_value;
  assign rsp.stored_length = res_length;

  dmht_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (TABLE_DEPTH)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (SLOT_W'(ram_wslot)),
    .re    (ram_re),
    .raddr (slot_idx),
    .rdata (ram_rdata)
  );

endmodule
`default_nettype wire

/* rtl/direct_mapped_hash_table_core.sv */
// Direct-mapped djb2 hash table: top level with configuration register.
//
// Key bytes arrive on req, one item per byte, with func, value_word and
// value_length taken on the byte flagged key_last. Each byte is folded into
// the running djb2 hash. The last byte queues a job; the back end works out
// hash modulo table_len (4 bits a cycle), reads the slot, applies
// insert/get/remove and loads the result register on rsp.
// One result per key; non-last bytes give none.
// A job is popped in IDLE and passes through the DIV, READ and EXEC states
// before the result register loads; the front and back ends overlap through
// a two-entry job queue.
// A stalled rsp holds its item; the back end carries on with the next job
// until it needs the result register, and req.ready drops once the queue
// fills.
// After reset the slot memory is cleared, one slot a cycle, over all
// TABLE_DEPTH slots; req.ready stays low meanwhile. table_len resets to 1024
// and may be written over the APB port only while the block is idle.
`timescale 1ns / 1ps
`default_nettype none
module direct_mapped_hash_table_core #(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  dmht_in_if.sink                                 req,
  dmht_out_if.source                              rsp,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [dmht_pkg::APB_ADDR_W-1:0]    paddr,
  input  wire logic [dmht_pkg::APB_DATA_W-1:0]    pwdata,
  output      logic [dmht_pkg::APB_DATA_W-1:0]    prdata,
  output      logic                               pready
);

  logic [dmht_pkg::LEN_W-1:0] table_len;
  logic                       table_ready;
  logic                       push;
  logic                       push_ready;
  dmht_pkg::job_t             push_data;
  logic                       job_pop;
  logic                       job_valid;
  dmht_pkg::job_t             job;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      table_len <= dmht_pkg::TABLE_LEN_RESET;
    end else if (psel && penable && pwrite && pready
                 && paddr[2] == dmht_pkg::REG_TABLE_LEN) begin
      table_len <= pwdata[dmht_pkg::LEN_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == dmht_pkg::REG_TABLE_LEN) begin
      prdata = dmht_pkg::APB_DATA_W'(table_len);
    end
  end

  dmht_front u_front (
    .clk        (clk),
    .rst        (rst),
    .enable     (table_ready),
    .req        (req),
    .push       (push),
    .push_data  (push_data),
    .push_ready (push_ready)
  );

  dmht_fifo u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_data),
    .push_ready (push_ready),
    .pop        (job_pop),
    .pop_data   (job),
    .pop_valid  (job_valid)
  );

  dmht_back #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .table_len   (table_len),
    .job_valid   (job_valid),
    .job         (job),
    .job_pop     (job_pop),
    .table_ready (table_ready),
    .rsp         (rsp)
  );

endmodule
`default_nettype wire
